// ===== hw/rtl/mpsl_pkg.sv =====
package mpsl_pkg;

  // channel count and derived widths
  localparam int unsigned NUM_CHANNELS = 10;
  localparam int unsigned IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // field widths
  localparam int unsigned CH_W    = 4;
  localparam int unsigned VAL_W   = 10;
  localparam int unsigned PWM_W   = 8;
  localparam int unsigned MS_W    = 8;
  localparam int unsigned SKEW_W  = 8;
  localparam int unsigned RAW_W   = SKEW_W + MS_W;
  localparam int unsigned FRAC_W  = 4;

  // channels that own a skew byte / an inversion bit
  localparam int unsigned SKEW_CHANNELS = 10;
  localparam int unsigned INV_W         = 10;
  localparam int unsigned SKEW_LO_W     = 64;
  localparam int unsigned SKEW_HI_W     = 16;

  // APB register file
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_INVERT  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SKEW_LO = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SKEW_HI = 2'd2;

  localparam logic [INV_W-1:0]     INVERT_RST  = '0;
  localparam logic [SKEW_LO_W-1:0] SKEW_LO_RST = 64'h0808_0808_0808_0808;
  localparam logic [SKEW_HI_W-1:0] SKEW_HI_RST = 16'h0808;

  typedef logic signed [PWM_W-1:0] level_t;
  typedef logic [IDX_W-1:0]        idx_t;

  localparam idx_t   LAST_IDX  = IDX_W'(NUM_CHANNELS - 1);
  localparam level_t PWM_MAX   = 8'sd127;
  localparam level_t PWM_MIN   = -8'sd127;

  // per-channel settings decoded from the register file
  typedef struct packed {
    logic [NUM_CHANNELS-1:0]             invert;
    logic [NUM_CHANNELS-1:0][SKEW_W-1:0] skew;
  } cfg_t;

  // write request into the level store
  typedef struct packed {
    logic   tgt_en;
    logic   out_en;
    idx_t   addr;
    level_t tgt;
    level_t out;
  } ram_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SET  = 4'b0010,
    ST_TICK = 4'b0100,
    ST_LAST = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/mpsl_cfg_regs.sv =====
module mpsl_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mpsl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mpsl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mpsl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output mpsl_pkg::cfg_t                     cfg_o
);

  logic [mpsl_pkg::INV_W-1:0]     invert_q;
  logic [mpsl_pkg::SKEW_LO_W-1:0] skew_lo_q;
  logic [mpsl_pkg::SKEW_HI_W-1:0] skew_hi_q;
  logic [mpsl_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  logic [mpsl_pkg::SKEW_LO_W+mpsl_pkg::SKEW_HI_W-1:0] skew_all;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[mpsl_pkg::APB_ADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= mpsl_pkg::INVERT_RST;
      skew_lo_q <= mpsl_pkg::SKEW_LO_RST;
      skew_hi_q <= mpsl_pkg::SKEW_HI_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        mpsl_pkg::REG_INVERT:  invert_q  <= pwdata[mpsl_pkg::INV_W-1:0];
        mpsl_pkg::REG_SKEW_LO: skew_lo_q <= pwdata[mpsl_pkg::SKEW_LO_W-1:0];
        mpsl_pkg::REG_SKEW_HI: skew_hi_q <= pwdata[mpsl_pkg::SKEW_HI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mpsl_pkg::REG_INVERT:  prdata = mpsl_pkg::APB_DATA_W'(invert_q);
      mpsl_pkg::REG_SKEW_LO: prdata = mpsl_pkg::APB_DATA_W'(skew_lo_q);
      mpsl_pkg::REG_SKEW_HI: prdata = mpsl_pkg::APB_DATA_W'(skew_hi_q);
      default:               prdata = '0;
    endcase
  end

  assign skew_all = {skew_hi_q, skew_lo_q};

  // channels past the register coverage get no inversion and zero skew
  for (genvar c = 0; c < mpsl_pkg::NUM_CHANNELS; c++) begin : g_chan
    if (c < mpsl_pkg::INV_W) begin : g_inv
      assign cfg_o.invert[c] = invert_q[c];
    end else begin : g_noinv
      assign cfg_o.invert[c] = 1'b0;
    end
    if (c < mpsl_pkg::SKEW_CHANNELS) begin : g_skew
      assign cfg_o.skew[c] = skew_all[c*mpsl_pkg::SKEW_W +: mpsl_pkg::SKEW_W];
    end else begin : g_noskew
      assign cfg_o.skew[c] = '0;
    end
  end

endmodule

// ===== hw/rtl/mpsl_level_ram.sv =====
module mpsl_level_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  mpsl_pkg::idx_t    rd_addr_i,
  input  mpsl_pkg::ram_wr_t wr_i,
  output mpsl_pkg::level_t  rd_tgt_o,
  output mpsl_pkg::level_t  rd_out_o
);

  mpsl_pkg::level_t tgt_mem [mpsl_pkg::NUM_CHANNELS];
  mpsl_pkg::level_t out_mem [mpsl_pkg::NUM_CHANNELS];

  // per-entry written flags; an unwritten entry reads as zero
  logic [mpsl_pkg::NUM_CHANNELS-1:0] tgt_vld_q;
  logic [mpsl_pkg::NUM_CHANNELS-1:0] out_vld_q;

  mpsl_pkg::level_t rd_tgt_q;
  mpsl_pkg::level_t rd_out_q;
  logic             rd_tgt_vld_q;
  logic             rd_out_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.tgt_en) begin
      tgt_mem[wr_i.addr] <= wr_i.tgt;
    end
    if (wr_i.out_en) begin
      out_mem[wr_i.addr] <= wr_i.out;
    end
    if (rd_en_i) begin
      rd_tgt_q <= tgt_mem[rd_addr_i];
      rd_out_q <= out_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_vld_q    <= '0;
      out_vld_q    <= '0;
      rd_tgt_vld_q <= 1'b0;
      rd_out_vld_q <= 1'b0;
    end else begin
      if (wr_i.tgt_en) begin
        tgt_vld_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.out_en) begin
        out_vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_tgt_vld_q <= tgt_vld_q[rd_addr_i];
        rd_out_vld_q <= out_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_tgt_o = rd_tgt_vld_q ? rd_tgt_q : '0;
  assign rd_out_o = rd_out_vld_q ? rd_out_q : '0;

endmodule

// ===== hw/rtl/mpsl_slew_unit.sv =====
module mpsl_slew_unit (
  input  logic                              clk_i,
  // ramp step: raw = skew * elapsed, registered alongside the memory read
  input  logic                              issue_i,
  input  logic [mpsl_pkg::SKEW_W-1:0]       skew_i,
  input  logic [mpsl_pkg::MS_W-1:0]         elapsed_i,
  input  mpsl_pkg::level_t                  cur_i,
  input  mpsl_pkg::level_t                  tgt_i,
  output mpsl_pkg::level_t                  next_o,
  output logic                              differ_o,
  // set path: clamp and optional negate
  input  logic signed [mpsl_pkg::VAL_W-1:0] set_value_i,
  input  logic                              invert_i,
  output mpsl_pkg::level_t                  set_level_o
);

  logic [mpsl_pkg::RAW_W-1:0]   raw_q;
  logic signed [mpsl_pkg::PWM_W:0] diff;
  logic [mpsl_pkg::PWM_W:0]     neg_diff;
  logic [mpsl_pkg::PWM_W-1:0]   mag;
  logic [mpsl_pkg::PWM_W-1:0]   step;
  logic signed [mpsl_pkg::PWM_W+1:0] moved;
  logic                         snap;
  mpsl_pkg::level_t             clamped;

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      raw_q <= mpsl_pkg::RAW_W'(skew_i) * mpsl_pkg::RAW_W'(elapsed_i);
    end
  end

  assign diff     = {tgt_i[mpsl_pkg::PWM_W-1], tgt_i} - {cur_i[mpsl_pkg::PWM_W-1], cur_i};
  assign neg_diff = -diff;
  assign mag      = diff[mpsl_pkg::PWM_W] ? neg_diff[mpsl_pkg::PWM_W-1:0]
                                          : diff[mpsl_pkg::PWM_W-1:0];
  assign differ_o = (diff != '0);
  assign snap     = {{(mpsl_pkg::RAW_W-mpsl_pkg::PWM_W-mpsl_pkg::FRAC_W){1'b0}},
                     mag, {mpsl_pkg::FRAC_W{1'b0}}} < raw_q;
  // without a snap, raw >> 4 <= mag, so the step fits in PWM_W bits
  assign step     = raw_q[mpsl_pkg::FRAC_W +: mpsl_pkg::PWM_W];

  always_comb begin
    if (diff[mpsl_pkg::PWM_W]) begin
      moved = {{2{cur_i[mpsl_pkg::PWM_W-1]}}, cur_i} - {2'b00, step};
    end else begin
      moved = {{2{cur_i[mpsl_pkg::PWM_W-1]}}, cur_i} + {2'b00, step};
    end
    if (!differ_o) begin
      next_o = cur_i;
    end else if (snap) begin
      next_o = tgt_i;
    end else begin
      next_o = moved[mpsl_pkg::PWM_W-1:0];
    end
  end

  always_comb begin
    if (set_value_i > mpsl_pkg::VAL_W'(mpsl_pkg::PWM_MAX)) begin
      clamped = mpsl_pkg::PWM_MAX;
    end else if (set_value_i < mpsl_pkg::VAL_W'(mpsl_pkg::PWM_MIN)) begin
      clamped = mpsl_pkg::PWM_MIN;
    end else begin
      clamped = set_value_i[mpsl_pkg::PWM_W-1:0];
    end
    set_level_o = invert_i ? -clamped : clamped;
  end

endmodule

// ===== hw/rtl/multichannel_pwm_slew_limiter.sv =====
// Channel   Direction  Handshake                       Payload
// request   in         start / busy                    req_type, channel, set_value,
//                                                      immediate, elapsed_ms
// result    out        res_valid (one-cycle strobe)    out_channel, pwm, drive_valid,
//                                                      status, last
// config    in         APB psel / penable / pready     invert_mask, skew_low, skew_high
//
// A set request is latched, then clamped/inverted and written to the level store.
// A tick is latched, then does one store read per channel, each followed in the next
// cycle by the slew update and write-back.
// The store's single read port sets the tick rate (one channel per cycle).
// Reset clears control state and the store's written flags; levels read as zero.
// Results are strobed for one cycle; the receiver cannot stall them.
module multichannel_pwm_slew_limiter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type_i,
  input  logic [mpsl_pkg::CH_W-1:0]          channel_i,
  input  logic signed [mpsl_pkg::VAL_W-1:0]  set_value_i,
  input  logic                               immediate_i,
  input  logic [mpsl_pkg::MS_W-1:0]          elapsed_ms_i,
  // result channel
  output logic                               res_valid_o,
  output logic [mpsl_pkg::CH_W-1:0]          out_channel_o,
  output logic signed [mpsl_pkg::PWM_W-1:0]  pwm_o,
  output logic                               drive_valid_o,
  output logic                               status_o,
  output logic                               last_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mpsl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mpsl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mpsl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  mpsl_pkg::cfg_t    cfg;
  mpsl_pkg::state_e  state_q, state_d;
  mpsl_pkg::idx_t    idx_q, idx_d;
  mpsl_pkg::idx_t    s1_idx_q;
  logic              s1_vld_q;
  logic              accept;

  // latched request
  logic                              req_type_q;
  logic [mpsl_pkg::CH_W-1:0]         chan_q;
  logic signed [mpsl_pkg::VAL_W-1:0] set_value_q;
  logic                              imm_q;
  logic [mpsl_pkg::MS_W-1:0]         elapsed_q;

  // set path
  logic [mpsl_pkg::CH_W:0]   ch_m1;
  mpsl_pkg::idx_t            set_idx;
  logic                      ch_ok;
  logic                      set_inv;
  mpsl_pkg::level_t          set_level;

  // tick path
  mpsl_pkg::level_t  rd_tgt, rd_out, next_level;
  logic              differ;
  logic              in_set, in_tick;
  mpsl_pkg::ram_wr_t ram_wr;

  // result register
  logic                      res_valid_d;
  logic [mpsl_pkg::CH_W-1:0] res_ch_d;
  mpsl_pkg::level_t          res_pwm_d;
  logic                      res_dv_d, res_st_d, res_last_d;

  mpsl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy    = (state_q != mpsl_pkg::ST_IDLE);
  assign accept  = start & ~busy;
  assign in_set  = (state_q == mpsl_pkg::ST_SET);
  assign in_tick = (state_q == mpsl_pkg::ST_TICK);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q  <= req_type_i;
      chan_q      <= channel_i;
      set_value_q <= set_value_i;
      imm_q       <= immediate_i;
      elapsed_q   <= elapsed_ms_i;
    end
  end

  // sequencer: IDLE -> SET -> IDLE, or IDLE -> TICK (one read per channel) -> LAST -> IDLE
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      mpsl_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = req_type_i ? mpsl_pkg::ST_TICK : mpsl_pkg::ST_SET;
          idx_d   = '0;
        end
      end
      mpsl_pkg::ST_SET:  state_d = mpsl_pkg::ST_IDLE;
      mpsl_pkg::ST_TICK: begin
        if (idx_q == mpsl_pkg::LAST_IDX) begin
          state_d = mpsl_pkg::ST_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      mpsl_pkg::ST_LAST: state_d = mpsl_pkg::ST_IDLE;
      default:           state_d = mpsl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpsl_pkg::ST_IDLE;
      idx_q    <= '0;
      s1_vld_q <= 1'b0;
      s1_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      s1_vld_q <= in_tick;
      s1_idx_q <= idx_q;
    end
  end

  // set request decode; channel numbers are 1-based
  assign ch_m1   = {1'b0, chan_q} - 1'b1;
  assign set_idx = ch_m1[mpsl_pkg::IDX_W-1:0];
  assign ch_ok   = (chan_q != '0) &&
                   ({1'b0, chan_q} <= (mpsl_pkg::CH_W+1)'(mpsl_pkg::NUM_CHANNELS));
  assign set_inv = ch_ok & cfg.invert[set_idx];

  mpsl_slew_unit u_slew (
    .clk_i       (clk_i),
    .issue_i     (in_tick),
    .skew_i      (cfg.skew[idx_q]),
    .elapsed_i   (elapsed_q),
    .cur_i       (rd_out),
    .tgt_i       (rd_tgt),
    .next_o      (next_level),
    .differ_o    (differ),
    .set_value_i (set_value_q),
    .invert_i    (set_inv),
    .set_level_o (set_level)
  );

  // set writes and tick write-backs never share a cycle
  always_comb begin
    ram_wr.tgt_en = in_set & ch_ok;
    ram_wr.out_en = (in_set & ch_ok & imm_q) | (s1_vld_q & differ);
    ram_wr.addr   = s1_vld_q ? s1_idx_q : set_idx;
    ram_wr.tgt    = set_level;
    ram_wr.out    = s1_vld_q ? next_level : set_level;
  end

  mpsl_level_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_tick),
    .rd_addr_i (idx_q),
    .wr_i      (ram_wr),
    .rd_tgt_o  (rd_tgt),
    .rd_out_o  (rd_out)
  );

  always_comb begin
    res_valid_d = in_set | s1_vld_q;
    if (s1_vld_q) begin
      res_ch_d   = mpsl_pkg::CH_W'({1'b0, s1_idx_q} + 1'b1);
      res_pwm_d  = next_level;
      res_dv_d   = differ;
      res_st_d   = 1'b0;
      res_last_d = (s1_idx_q == mpsl_pkg::LAST_IDX);
    end else begin
      res_ch_d   = chan_q;
      res_pwm_d  = ch_ok ? set_level : '0;
      res_dv_d   = ch_ok & imm_q;
      res_st_d   = ~ch_ok;
      res_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      out_channel_o <= res_ch_d;
      pwm_o         <= res_pwm_d;
      drive_valid_o <= res_dv_d;
      status_o      <= res_st_d;
      last_o        <= res_last_d;
    end
  end

  // no tick channel may still be in flight once the block reports idle
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !s1_vld_q)
    else $error("tick update pending while idle");

  // a set request answers through the SET state and the result register, as a final result
  a_set_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !req_type_i) |=> ##1 (res_valid_o && last_o))
    else $error("set request result missing");

  // a rejected channel never drives
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o) |-> (!drive_valid_o && last_o && pwm_o == '0))
    else $error("rejected request produced a drive");

  // levels stay inside the symmetric range
  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (pwm_o != -8'sd128))
    else $error("pwm out of range");

endmodule
